// ----- rtl/core/dct_pkg.sv -----
// Shared types, codes and widths for the DMA completion tracker.
package dct_pkg;

    localparam int unsigned MAX_SLOTS_DEF = 8;
    localparam int unsigned DEPTH_RST_CAP = 8;

    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned DEPTH_W = 4;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned OP_W    = 2;

    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = 24;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    localparam logic [FUNC_W-1:0] FUNC_SUBMIT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RETURN = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    localparam logic [OP_W-1:0] OP_REJECT    = 2'd0;
    localparam logic [OP_W-1:0] OP_SUBMITTED = 2'd1;
    localparam logic [OP_W-1:0] OP_RET_IN    = 2'd2;
    localparam logic [OP_W-1:0] OP_RET_OUT   = 2'd3;

    localparam logic REG_IDX_DEPTH = 1'b0;

    typedef enum logic [1:0] {
        SLOT_FREE      = 2'd0,
        SLOT_SUBMITTED = 2'd1,
        SLOT_RETURNED  = 2'd2
    } t_slot;

    typedef enum logic [1:0] {
        ASEL_IDX  = 2'd0,
        ASEL_HEAD = 2'd1,
        ASEL_SCAN = 2'd2,
        ASEL_TAIL = 2'd3
    } t_asel;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_RETIRE = 5'b00100,
        S_SCAN   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    typedef struct packed {
        logic  latch_in;
        t_asel asel;
        logic  exec_op;
        logic  retire_step;
        logic  scan_init;
        logic  scan_step;
        logic  scan_hit;
        logic  load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic ret_ok;
        logic retire_ok;
        logic inflight_none;
        logic scan_hit;
        logic scan_last;
    } t_dp_stat;

    typedef struct packed {
        logic               releasable;
        logic [CNT_W-1:0]   in_flight_count;
        logic [CNT_W-1:0]   occupied_count;
        logic [IDX_W-1:0]   oldest_in_flight;
        logic               in_flight_found;
        logic [IDX_W-1:0]   submit_index;
        logic               can_submit;
        logic [OP_W-1:0]    op_status;
    } t_result;

endpackage

// ----- rtl/core/dct_ctrl.sv -----
// Sequencing state machine for the DMA completion tracker.
module dct_ctrl
    import dct_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.asel  = ASEL_IDX;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.asel    = ASEL_IDX;
                o_cmd.exec_op = 1'b1;
                if (i_stat.ret_ok) begin
                    n_state = S_RETIRE;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_RETIRE: begin
                o_cmd.asel = ASEL_HEAD;
                if (i_stat.retire_ok) begin
                    o_cmd.retire_step = 1'b1;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.asel = ASEL_SCAN;
                if (i_stat.inflight_none) begin
                    n_state = S_DONE;
                end else if (i_stat.scan_hit) begin
                    o_cmd.scan_hit = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    if (i_stat.scan_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                o_cmd.asel = ASEL_TAIL;
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/core/dct_datapath.sv -----
// Slot ring, pointers, counters and result register of the completion tracker.
module dct_datapath
    import dct_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [DEPTH_W-1:0]  i_cfg_depth,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [IDX_W-1:0]    i_req_idx,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    output logic [DEPTH_W-1:0]  o_depth,
    output t_result             o_result
);

    localparam int unsigned PTR_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int unsigned CW    = (PTR_W > DEPTH_W) ? PTR_W : DEPTH_W;
    localparam logic [DEPTH_W-1:0] DEPTH_RST =
        DEPTH_W'((MAX_SLOTS < DEPTH_RST_CAP) ? MAX_SLOTS : DEPTH_RST_CAP);

    // Slot states sit in flip-flops so that reset and a depth write clear them at once.
    t_slot              r_slot [MAX_SLOTS];
    logic [PTR_W-1:0]   r_head, r_tail;
    logic [CNT_W-1:0]   r_occ, r_infl;
    logic [DEPTH_W-1:0] r_depth;
    logic [FUNC_W-1:0]  r_func;
    logic [IDX_W-1:0]   r_idx;
    logic [OP_W-1:0]    r_op;
    logic [PTR_W-1:0]   r_scan_p;
    logic [CNT_W-1:0]   r_scan_k;
    logic               r_found;
    logic [PTR_W-1:0]   r_oldest;
    t_result            r_result;

    logic [PTR_W-1:0]   idx_ptr;
    logic [PTR_W-1:0]   rd_addr;
    t_slot              rd_slot;
    logic               idx_in_ring;
    logic               sub_ok;
    logic               ret_ok;
    logic               space_ok;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                   input logic [DEPTH_W-1:0] d);
        logic [CW-1:0] pn;
        pn = CW'(p) + CW'(1);
        if (pn >= CW'(d)) begin
            return '0;
        end
        return PTR_W'(pn);
    endfunction

    assign idx_ptr     = PTR_W'(CW'(r_idx));
    assign idx_in_ring = (CW'(r_idx) < CW'(r_depth));
    assign space_ok    = (CNT_W'(r_occ) < CNT_W'(r_depth));

    always_comb begin
        case (i_cmd.asel)
            ASEL_IDX:  rd_addr = idx_ptr;
            ASEL_HEAD: rd_addr = r_head;
            ASEL_SCAN: rd_addr = r_scan_p;
            ASEL_TAIL: rd_addr = r_tail;
            default:   rd_addr = r_head;
        endcase
    end

    assign rd_slot = r_slot[rd_addr];

    assign sub_ok = (r_func == FUNC_SUBMIT) && idx_in_ring && space_ok &&
                    (CW'(r_idx) == CW'(r_tail)) && (rd_slot == SLOT_FREE);
    assign ret_ok = (r_func == FUNC_RETURN) && idx_in_ring &&
                    (rd_slot == SLOT_SUBMITTED) && (r_infl != '0) && (r_occ != '0);

    assign o_stat.ret_ok        = ret_ok;
    assign o_stat.retire_ok     = (r_occ != '0) && (rd_slot == SLOT_RETURNED);
    assign o_stat.inflight_none = (r_infl == '0);
    assign o_stat.scan_hit      = (rd_slot == SLOT_SUBMITTED);
    assign o_stat.scan_last     = ({1'b0, r_scan_k} + 5'd1) >= {1'b0, r_depth};

    // Ring state: cleared by reset and by a valid depth write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                r_slot[i] <= SLOT_FREE;
            end
            r_head  <= '0;
            r_tail  <= '0;
            r_occ   <= '0;
            r_infl  <= '0;
            r_depth <= i_rst_n ? i_cfg_depth : DEPTH_RST;
        end else begin
            if (i_cmd.exec_op) begin
                if (sub_ok) begin
                    r_slot[idx_ptr] <= SLOT_SUBMITTED;
                    r_tail          <= next_ptr(r_tail, r_depth);
                    r_occ           <= r_occ + CNT_W'(1);
                    r_infl          <= r_infl + CNT_W'(1);
                end else if (ret_ok) begin
                    r_slot[idx_ptr] <= SLOT_RETURNED;
                    r_infl          <= r_infl - CNT_W'(1);
                end
            end
            if (i_cmd.retire_step) begin
                r_slot[r_head] <= SLOT_FREE;
                r_head         <= next_ptr(r_head, r_depth);
                r_occ          <= r_occ - CNT_W'(1);
            end
        end
    end

    // Request, scan and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_func <= i_func;
            r_idx  <= i_req_idx;
        end
        if (i_cmd.exec_op) begin
            if (sub_ok) begin
                r_op <= OP_SUBMITTED;
            end else if (ret_ok) begin
                r_op <= (CW'(r_idx) == CW'(r_head)) ? OP_RET_IN : OP_RET_OUT;
            end else begin
                r_op <= OP_REJECT;
            end
        end
        if (i_cmd.scan_init) begin
            r_scan_p <= r_head;
            r_scan_k <= '0;
            r_found  <= 1'b0;
            r_oldest <= '0;
        end
        if (i_cmd.scan_step) begin
            r_scan_p <= next_ptr(r_scan_p, r_depth);
            r_scan_k <= r_scan_k + CNT_W'(1);
        end
        if (i_cmd.scan_hit) begin
            r_found  <= 1'b1;
            r_oldest <= r_scan_p;
        end
        if (i_cmd.load_out) begin
            r_result.op_status        <= r_op;
            r_result.can_submit       <= space_ok && (rd_slot == SLOT_FREE);
            r_result.submit_index     <= IDX_W'(CW'(r_tail));
            r_result.in_flight_found  <= r_found;
            r_result.oldest_in_flight <= IDX_W'(CW'(r_oldest));
            r_result.occupied_count   <= r_occ;
            r_result.in_flight_count  <= r_infl;
            r_result.releasable       <= (r_occ == '0) && (r_infl == '0);
        end
    end

    assign o_depth  = r_depth;
    assign o_result = r_result;

endmodule

// ----- rtl/core/dma_completion_tracker.sv -----
// Top level of the DMA completion tracker: request/result streams and depth register.
//
//  channel   direction  handshake                 payload
//  s (req)   in         i_s_tvalid / o_s_tready   i_s_tdata : func, req_idx
//  m (res)   out        o_m_tvalid / i_m_tready   o_m_tdata : status word
//  apb       in         psel & penable & pwrite   queue_depth at address 0
//
// One request at a time. A request is accepted in idle, then checked and
// updated, then the head is retired (returns only), then the oldest-in-flight
// scan visits up to queue_depth slots, and last the result is loaded; the steps
// run one after another, set by the single read port on the slot ring.
// The result register frees the request side while a result waits on i_m_tready.
// Reset (synchronous, i_rst_n low) and a valid depth write clear the ring.
module dma_completion_tracker
    import dct_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request stream
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // [1:0] func, [4:2] req_idx, [7:5] zero
    // result stream
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,   // [1:0] op_status, [2] can_submit,
                                             // [5:3] submit_index, [6] in_flight_found,
                                             // [9:7] oldest_in_flight,
                                             // [13:10] occupied_count,
                                             // [17:14] in_flight_count,
                                             // [18] releasable, [23:19] zero
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    t_dp_cmd            cmd;
    t_dp_stat           stat;
    t_result            result;
    logic [DEPTH_W-1:0] depth;
    logic [DEPTH_W-1:0] wr_depth;
    logic               apb_wr;
    logic               cfg_we;

    // Decode the depth register; drop writes of zero or above the slot count.
    assign pready   = 1'b1;
    assign apb_wr   = psel && penable && pwrite && pready;
    assign wr_depth = pwdata[DEPTH_W-1:0];
    assign cfg_we   = apb_wr && (paddr[2] == REG_IDX_DEPTH) && (wr_depth != '0) &&
                      (32'(wr_depth) <= MAX_SLOTS);
    assign prdata   = (paddr[2] == REG_IDX_DEPTH) ? APB_DW'(depth) : '0;

    dct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_out_ready (i_m_tready),
        .i_stat      (stat),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .o_cmd       (cmd)
    );

    dct_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_depth  (wr_depth),
        .i_func       (i_s_tdata[1:0]),
        .i_req_idx    (i_s_tdata[4:2]),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_depth      (depth),
        .o_result     (result)
    );

    // Pack the result fields from bit 0 upwards; pad to whole bytes.
    assign o_m_tdata = M_DATA_W'(result);

`ifndef SYNTHESIS
    // A request is accepted only in idle, so ready drops right after acceptance.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while another is in progress");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_m_tvalid || i_m_tready))
        else $error("result register overwritten under back-pressure");

    // Every in-flight slot is also occupied.
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[13:10] >= o_m_tdata[17:14]))
        else $error("in-flight count exceeds occupied count");

    // The scan finds a submitted slot exactly when something is in flight.
    a_scan_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[6] == (o_m_tdata[17:14] != 4'd0)))
        else $error("oldest in-flight scan disagrees with in-flight count");
`endif

endmodule
